>>> rtl/block_min_max_mean_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// block_min_max_mean_tracker_unit_macros.svh
// Assertion macros shared by the checkers of the tracker
// ----------------------------------------------------------------------------
`ifndef BLOCK_MIN_MAX_MEAN_TRACKER_UNIT_MACROS_SVH
`define BLOCK_MIN_MAX_MEAN_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared constants and types of the block min/max/mean tracker
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int MAX_BLOCK  = 1024;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 11;
  localparam int LEN_W      = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W      = DATA_W + $clog2(MAX_BLOCK);
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_BLOCK_LENGTH   = 1'b0,
    CFG_EVENTS_ENABLED = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WAIT
  } bk_state_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] ovr_min;
    logic signed [DATA_W-1:0] ovr_max;
    logic                     done;
    logic signed [DATA_W-1:0] blk_min;
    logic signed [DATA_W-1:0] blk_max;
    logic signed [SUM_W-1:0]  blk_sum;
    logic [LEN_W-1:0]         blk_len;
  } job_t;

endpackage

>>> rtl/mmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_front
// Accepts samples, tracks extremes and block accumulators, queues jobs
// ----------------------------------------------------------------------------
module mmt_front import mmt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     q_full,
  output logic                     push,
  output job_t                     push_job
);

  logic [CFG_W-1:0]         block_length_r;
  logic                     events_enabled_r;
  logic signed [DATA_W-1:0] ovr_min_r, ovr_min_nxt;
  logic signed [DATA_W-1:0] ovr_max_r, ovr_max_nxt;
  logic signed [DATA_W-1:0] run_min_r, run_min_nxt;
  logic signed [DATA_W-1:0] run_max_r, run_max_nxt;
  logic signed [SUM_W-1:0]  run_sum_r, run_sum_nxt;
  logic [LEN_W-1:0]         count_r, count_nxt;
  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         count_inc;
  logic                     done;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (block_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(block_length_r) > 32'(MAX_BLOCK)) begin
      len_eff = LEN_W'(MAX_BLOCK);
    end else begin
      len_eff = LEN_W'(block_length_r);
    end
  end

  always_comb begin
    ovr_min_nxt = (in_sample < ovr_min_r) ? in_sample : ovr_min_r;
    ovr_max_nxt = (in_sample > ovr_max_r) ? in_sample : ovr_max_r;
    run_min_nxt = (in_sample < run_min_r) ? in_sample : run_min_r;
    run_max_nxt = (in_sample > run_max_r) ? in_sample : run_max_r;
    run_sum_nxt = run_sum_r + {{(SUM_W-DATA_W){in_sample[DATA_W-1]}}, in_sample};
    count_inc   = count_r + 1'b1;
    done        = events_enabled_r && (count_inc >= len_eff);
    count_nxt   = count_inc;

    push_job.ovr_min = ovr_min_nxt;
    push_job.ovr_max = ovr_max_nxt;
    push_job.done    = done;
    push_job.blk_min = done ? run_min_nxt : '0;
    push_job.blk_max = done ? run_max_nxt : '0;
    push_job.blk_sum = run_sum_nxt;
    push_job.blk_len = len_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r   <= CFG_W'(8);
      events_enabled_r <= 1'b0;
      ovr_min_r        <= DATA_MAX;
      ovr_max_r        <= DATA_MIN;
      run_min_r        <= DATA_MAX;
      run_max_r        <= DATA_MIN;
      run_sum_r        <= '0;
      count_r          <= '0;
    end else if (cfg_we) begin
      // any register write restarts the block
      if (cfg_index == CFG_BLOCK_LENGTH) begin
        block_length_r <= cfg_wdata;
      end else begin
        events_enabled_r <= cfg_wdata[0];
      end
      run_min_r <= DATA_MAX;
      run_max_r <= DATA_MIN;
      run_sum_r <= '0;
      count_r   <= '0;
    end else if (push) begin
      ovr_min_r <= ovr_min_nxt;
      ovr_max_r <= ovr_max_nxt;
      if (done) begin
        run_min_r <= DATA_MAX;
        run_max_r <= DATA_MIN;
        run_sum_r <= '0;
        count_r   <= '0;
      end else if (events_enabled_r) begin
        run_min_r <= run_min_nxt;
        run_max_r <= run_max_nxt;
        run_sum_r <= run_sum_nxt;
        count_r   <= count_nxt;
      end
    end
  end

endmodule

>>> rtl/mmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_queue
// Short job queue between the front and back parts
// ----------------------------------------------------------------------------
module mmt_queue import mmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_head
);

  job_t               q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r;

  assign q_valid = (fill_r != '0);
  assign q_full  = (fill_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_head  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

>>> rtl/mmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_back
// Drains jobs, runs the serial mean divider, holds the result register
// ----------------------------------------------------------------------------
module mmt_back import mmt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  job_t                     q_head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_overall_min,
  output logic signed [DATA_W-1:0] out_overall_max,
  output logic                     out_block_done,
  output logic signed [DATA_W-1:0] out_block_min,
  output logic signed [DATA_W-1:0] out_block_max,
  output logic signed [DATA_W-1:0] out_block_mean
);

  bk_state_t              state_r, state_nxt;
  job_t                   job_r;
  logic [LEN_W:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [LEN_W-1:0]       dvs_r;
  logic                   neg_r;
  logic [DIV_CNT_W-1:0]   step_r;
  logic [LEN_W:0]         rem_sh;
  logic [SUM_W-1:0]       quo_signed;
  logic                   slot_free;
  logic                   load_direct;
  logic                   div_load;
  logic                   load_div;
  logic                   out_valid_r;
  logic signed [DATA_W-1:0] ovr_min_r, ovr_max_r, blk_min_r, blk_max_r, mean_r;
  logic                   done_r;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && slot_free && q_head.done) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == DIV_CNT_W'(SUM_W - 1)) begin
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop         = 1'b0;
    load_direct = 1'b0;
    div_load    = 1'b0;
    load_div    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop         = q_valid && slot_free;
        load_direct = pop && !q_head.done;
        div_load    = pop && q_head.done;
      end
      BK_WAIT: load_div = slot_free;
      default: ;
    endcase
  end

  // one quotient bit per cycle on the magnitudes
  always_comb begin
    rem_sh = {rem_r[LEN_W-1:0], quo_r[SUM_W-1]};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sh - {1'b0, dvs_r};
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
    quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      job_r  <= q_head;
      dvs_r  <= q_head.blk_len;
      neg_r  <= q_head.blk_sum[SUM_W-1];
      rem_r  <= '0;
      quo_r  <= q_head.blk_sum[SUM_W-1] ? (~q_head.blk_sum + 1'b1) : q_head.blk_sum;
      step_r <= '0;
    end else if (state_r == BK_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      ovr_min_r <= q_head.ovr_min;
      ovr_max_r <= q_head.ovr_max;
      done_r    <= 1'b0;
      blk_min_r <= '0;
      blk_max_r <= '0;
      mean_r    <= '0;
    end else if (load_div) begin
      ovr_min_r <= job_r.ovr_min;
      ovr_max_r <= job_r.ovr_max;
      done_r    <= 1'b1;
      blk_min_r <= job_r.blk_min;
      blk_max_r <= job_r.blk_max;
      mean_r    <= quo_signed[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_direct || load_div) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_overall_min = ovr_min_r;
  assign out_overall_max = ovr_max_r;
  assign out_block_done  = done_r;
  assign out_block_min   = blk_min_r;
  assign out_block_max   = blk_max_r;
  assign out_block_mean  = mean_r;

endmodule

>>> rtl/block_min_max_mean_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_min_max_mean_tracker_unit
// Running and per-block min/max/mean statistics over a signed sample stream
// ----------------------------------------------------------------------------
// Every accepted sample gives one result. A sample that does not close a
// block passes through the job queue and the result register, so such
// samples stream at one per clock while the output is not stalled and the
// back part is not dividing. A sample that closes a block takes the serial
// divider in the back part (one quotient bit per cycle over the 42-bit
// block sum); during that time the front keeps taking samples until its
// two-entry job queue is full. The divider keeps running while a result is
// stalled, and the result register reloads in the same cycle its transaction is taken.
// Configuration writes take effect at once and restart the current block.
module block_min_max_mean_tracker_unit import mmt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_overall_min,
  output logic signed [DATA_W-1:0] out_overall_max,
  output logic                     out_block_done,
  output logic signed [DATA_W-1:0] out_block_min,
  output logic signed [DATA_W-1:0] out_block_max,
  output logic signed [DATA_W-1:0] out_block_mean,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t push_job;
  job_t q_head;

  mmt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  mmt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_head   (q_head)
  );

  mmt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_overall_min (out_overall_min),
    .out_overall_max (out_overall_max),
    .out_block_done  (out_block_done),
    .out_block_min   (out_block_min),
    .out_block_max   (out_block_max),
    .out_block_mean  (out_block_mean)
  );

endmodule

>>> rtl/mmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks of the tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "block_min_max_mean_tracker_unit_macros.svh"

module mmt_checker import mmt_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [DATA_W-1:0] in_sample,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_overall_min,
  input logic signed [DATA_W-1:0] out_overall_max,
  input logic                     out_block_done,
  input logic signed [DATA_W-1:0] out_block_min,
  input logic signed [DATA_W-1:0] out_block_max,
  input logic signed [DATA_W-1:0] out_block_mean
);

  // no block closed: block fields read zero
  `MMT_ASSERT_NOW(a_idle_block_zero, out_valid && !out_block_done, out_block_min == '0 && out_block_max == '0 && out_block_mean == '0, "block fields not zero without block_done")

  // mean lies between block extremes
  `MMT_ASSERT_NOW(a_mean_in_range, out_valid && out_block_done, out_block_min <= out_block_mean && out_block_mean <= out_block_max, "block mean outside block min/max")

  // every result includes a sample, so extremes are ordered
  `MMT_ASSERT_NOW(a_overall_order, out_valid, out_overall_min <= out_overall_max, "overall min above overall max")

  // stalled result holds
  `MMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_overall_min) && $stable(out_block_mean), "stalled result changed")

  // stalled sample holds
  `MMT_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_sample), "stalled sample changed")

endmodule

bind block_min_max_mean_tracker_unit mmt_checker u_mmt_checker (.*);
